// ===== rtl/assert_macros.svh =====
// Assertion macros used by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define PPBF_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that cond implies prop in the next cycle.
`define PPBF_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/ppbf_pkg.sv =====
// Package with the shared constants and command/status types of the prime power base finder.
`timescale 1ns / 1ps
package ppbf_pkg;

	localparam int VALUE_BITS_DEF = 40;
	localparam int FIRST_DIVISOR  = 2;

	typedef struct packed {
		logic load_item;
		logic div_start;
		logic take_quot;
		logic next_div;
		logic take_factor;
		logic set_multi;
		logic load_out;
	} ppbf_cmd_t;

	typedef struct packed {
		logic div_done;
		logic loop_ok;
		logic rem_zero;
		logic found_one;
		logic removing;
		logic out_free;
	} ppbf_status_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LAUNCH = 5'b00010,
		S_WAIT   = 5'b00100,
		S_CHECK  = 5'b01000,
		S_FINISH = 5'b10000
	} ppbf_state_t;

endpackage

// ===== rtl/ppbf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppbf_div #(
	parameter int VALUE_BITS = ppbf_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] num,
	input  logic [VALUE_BITS-1:0] den,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quot,
	output logic [VALUE_BITS-1:0] rem
);
	import ppbf_pkg::*;

	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] den_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			// shift in the next numerator bit, subtract when it fits
			rem_q <= fits ? VALUE_BITS'(trial - {1'b0, den_q}) : trial[VALUE_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/ppbf_dp.sv =====
// Datapath: cofactor, divisor, found prime and output register around the divider.
`timescale 1ns / 1ps
module ppbf_dp #(
	parameter int VALUE_BITS = ppbf_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppbf_pkg::ppbf_cmd_t    cmd,
	output ppbf_pkg::ppbf_status_t st,
	input  logic [VALUE_BITS-1:0]  value_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_BITS-1:0]  base_out
);
	import ppbf_pkg::*;

	logic [VALUE_BITS-1:0] rest_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS-1:0] base_q;
	logic [VALUE_BITS-1:0] out_q;
	logic                  found_q;
	logic                  removing_q;
	logic                  multi_q;
	logic                  out_valid_q;
	logic                  div_done;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] rem;
	logic                  rest_gt1;
	logic [VALUE_BITS-1:0] result;

	ppbf_div #(.VALUE_BITS(VALUE_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (rest_q),
		.den    (div_q),
		.done   (div_done),
		.quot   (quot),
		.rem    (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			removing_q  <= 1'b0;
			multi_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				found_q    <= 1'b0;
				removing_q <= 1'b0;
				multi_q    <= 1'b0;
			end else begin
				if (cmd.take_factor) begin
					found_q    <= 1'b1;
					removing_q <= 1'b1;
				end
				if (cmd.next_div) begin
					removing_q <= 1'b0;
				end
				if (cmd.set_multi) begin
					multi_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			rest_q <= value_in;
			div_q  <= VALUE_BITS'(FIRST_DIVISOR);
		end else begin
			if (cmd.take_quot || cmd.take_factor) begin
				rest_q <= quot;
			end
			if (cmd.take_factor) begin
				base_q <= div_q;
			end
			if (cmd.next_div) begin
				div_q <= div_q + 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_q <= result;
		end
	end

	// a leftover cofactor above one is one more distinct prime
	assign rest_gt1 = rest_q > VALUE_BITS'(1);

	always_comb begin
		if (multi_q) begin
			result = VALUE_BITS'(1);
		end else if (found_q) begin
			result = rest_gt1 ? VALUE_BITS'(1) : base_q;
		end else begin
			result = rest_gt1 ? rest_q : VALUE_BITS'(1);
		end
	end

	assign st.div_done  = div_done;
	assign st.loop_ok   = div_q <= quot;
	assign st.rem_zero  = rem == '0;
	assign st.found_one = found_q;
	assign st.removing  = removing_q;
	assign st.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign base_out  = out_q;

endmodule

// ===== rtl/ppbf_ctrl.sv =====
// Controller state machine that steps the trial division.
`timescale 1ns / 1ps
module ppbf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  ppbf_pkg::ppbf_status_t st,
	output ppbf_pkg::ppbf_cmd_t    cmd
);
	import ppbf_pkg::*;

	ppbf_state_t state_q;
	ppbf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_LAUNCH;
				end
			end
			S_LAUNCH: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (st.div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (st.removing) begin
					// keep dividing out the prime until it no longer divides
					if (st.rem_zero) begin
						cmd.take_quot = 1'b1;
					end else begin
						cmd.next_div = 1'b1;
					end
					state_d = S_LAUNCH;
				end else if (!st.loop_ok) begin
					state_d = S_FINISH;
				end else if (st.rem_zero) begin
					if (st.found_one) begin
						// second distinct prime fixes the answer
						cmd.set_multi = 1'b1;
						state_d       = S_FINISH;
					end else begin
						cmd.take_factor = 1'b1;
						state_d         = S_LAUNCH;
					end
				end else begin
					cmd.next_div = 1'b1;
					state_d      = S_LAUNCH;
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/prime_power_base_finder_core.sv =====
// Top level of the prime power base finder: controller, datapath and checks.
//
//  Channel  Signals                       Direction  Payload
//  input    in_valid / in_stall           in         value_in  [VALUE_BITS-1:0]
//  output   out_valid / out_stall         out        base_out  [VALUE_BITS-1:0]
//
// One item at a time. Each trial division passes through the bit-serial divider
// (launch, VALUE_BITS shift steps, done, check), and one item needs about
// sqrt(n) + number of prime factors such divisions, plus the load and finish steps.
// The result sits in an output register; the next item is taken while it waits.
// A finished item holds in the last state until the output register is free.
// Reset clears the controller and the valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prime_power_base_finder_core #(
	parameter int VALUE_BITS = ppbf_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] base_out
);
	import ppbf_pkg::*;

	ppbf_cmd_t    cmd;
	ppbf_status_t st;

	ppbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ppbf_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.base_out  (base_out)
	);

	`PPBF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not start work")
	`PPBF_ASSERT_NOW(a_load_when_free, cmd.load_out, st.out_free, "result overwrote a waiting item")
	`PPBF_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared without work")
	`PPBF_ASSERT_NOW(a_base_nonzero, out_valid, base_out != '0, "base of zero delivered")

endmodule

// ===== tb/ppbf_base_checker.sv =====
// Channel monitor for the prime power base finder: predicts each base and compares results.
`timescale 1ns / 1ps
module ppbf_base_checker #(
	parameter int VALUE_BITS = ppbf_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [VALUE_BITS-1:0] base_out,
	output int                    mismatch_count,
	output int                    bases_checked,
	output int                    bases_pending
);
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [VALUE_BITS-1:0] base;
	} base_entry_t;

	base_entry_t expected_bases[$];
	int errors_seen = 0;
	int checked_seen = 0;

	// Trial division; a second distinct prime settles the answer at once.
	function automatic logic [VALUE_BITS-1:0] prime_power_base_of(
		input logic [VALUE_BITS-1:0] value
	);
		longint unsigned cofactor;
		longint unsigned divisor;
		longint unsigned base;
		int primes_found;
		cofactor = 64'(value);
		divisor = 64'(ppbf_pkg::FIRST_DIVISOR);
		base = 1;
		primes_found = 0;
		while (divisor <= cofactor / divisor) begin
			if (cofactor % divisor == 0) begin
				primes_found++;
				base = divisor;
				if (primes_found >= 2)
					return VALUE_BITS'(1);
				while (cofactor % divisor == 0)
					cofactor = cofactor / divisor;
			end
			divisor++;
		end
		// leftover cofactor above one is one more prime
		if (cofactor > 1) begin
			primes_found++;
			base = cofactor;
		end
		return (primes_found == 1) ? base[VALUE_BITS-1:0] : VALUE_BITS'(1);
	endfunction

	always @(posedge clk) begin : watch_channels
		base_entry_t head;
		base_entry_t incoming;
		if (arst_n) begin
			// retire results before taking new items, so a stray result never
			// matches an item accepted at the same edge
			if (out_valid && !out_stall) begin
				if (expected_bases.size() == 0) begin
					errors_seen++;
					if (errors_seen <= 10)
						$display("%0t: base %0d arrived with no item outstanding",
							$time, base_out);
				end else begin
					head = expected_bases.pop_front();
					checked_seen++;
					if (base_out !== head.base) begin
						errors_seen++;
						if (errors_seen <= 10)
							$display("%0t: value %0d: expected base %0d, got %0d",
								$time, head.value, head.base, base_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				incoming.value = value_in;
				incoming.base = prime_power_base_of(value_in);
				expected_bases = {expected_bases, incoming};
			end
		end
		mismatch_count <= errors_seen;
		bases_checked <= checked_seen;
		bases_pending <= expected_bases.size();
	end
endmodule

// ===== tb/tb_prime_power_base_finder_core.sv =====
// Testbench top for the prime power base finder core: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_prime_power_base_finder_core;
	import ppbf_pkg::*;

	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 200;
	localparam int PRESSURE_ITEMS = 12;
	localparam int RANDOM_PER_PHASE = 22;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [VALUE_BITS-1:0] value_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VALUE_BITS-1:0] base_out;

	logic hold_off = 1'b0;
	logic pressure_req = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   values_sent = 0;
	int   idle_by_phase[4] = '{0, 52, 0, 8};
	int   stall_by_phase[4] = '{0, 0, 52, 8};
	int   mismatch_count;
	int   bases_checked;
	int   bases_pending;

	longint unsigned small_primes[$] = {2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
		47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127};

	// zero and one, tiny primes and powers, early exit on a second prime,
	// leftover cofactor as a second prime, all-ones and top-bit values
	longint unsigned directed_values[$] = {0, 1, 2, 3, 4, 6, 9, 10, 12, 15, 30, 49, 97, 128,
		4093, 1048573, VALUE_MAX, VALUE_MAX - 1, 64'd1 << (VALUE_BITS - 1), 847288609443,
		64'd1021 * 64'd1021 * 64'd1021 * 64'd1021};

	prime_power_base_finder_core #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value_in (value_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.base_out (base_out)
	);

	ppbf_base_checker #(
		.VALUE_BITS(VALUE_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value_in      (value_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.base_out      (base_out),
		.mismatch_count(mismatch_count),
		.bases_checked (bases_checked),
		.bases_pending (bases_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	initial begin : receiver_hold_off
		wait (pressure_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Keep the search short: small values, small-base powers, early exits.
	function automatic longint unsigned next_random_value();
		longint unsigned wide;
		longint unsigned p;
		longint unsigned q;
		longint unsigned result;
		int unsigned pick;
		int unsigned width;
		wide = {$urandom, $urandom};
		wide = wide & VALUE_MAX;
		pick = $urandom_range(99);
		if (pick < 35) begin
			result = $urandom_range(4095, 1);
		end else if (pick < 55) begin
			p = small_primes[$urandom_range(small_primes.size() - 1)];
			result = p;
			repeat ($urandom_range(39))
				if (result * p <= VALUE_MAX)
					result = result * p;
		end else if (pick < 75) begin
			// two distinct small primes times a wide cofactor
			p = small_primes[$urandom_range(small_primes.size() - 1)];
			do
				q = small_primes[$urandom_range(small_primes.size() - 1)];
			while (q == p);
			result = (wide / (p * q)) * p * q;
			if (result == 0)
				result = p * q;
		end else begin
			// small value shifted up: a run of twos, then a short search
			result = $urandom_range(4095, 1);
			width = 0;
			while ((result >> width) != 0)
				width++;
			result = result << $urandom_range(VALUE_BITS - width);
		end
		return result;
	endfunction

	task automatic offer_value(input longint unsigned value);
		longint unsigned noise;
		while ($urandom_range(99) < idle_pct) begin
			noise = {$urandom, $urandom};
			in_valid <= 1'b0;
			value_in <= noise[VALUE_BITS-1:0];
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= value[VALUE_BITS-1:0];
		values_sent++;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	initial begin : drive_values
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_values[i])
			offer_value(directed_values[i]);

		// hold the output side while items keep coming, so the input backs up
		pressure_req <= 1'b1;
		repeat (PRESSURE_ITEMS)
			offer_value($urandom_range(255, 1));

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_by_phase[phase];
			stall_pct <= stall_by_phase[phase];
			repeat (RANDOM_PER_PHASE)
				offer_value(next_random_value());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (bases_pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d values (%0d directed, rest random), %0d bases checked,",
			values_sent, directed_values.size(), bases_checked);
		$display("idling off, sender only, receiver only and both, and a %0d-cycle hold.",
			HOLD_CYCLES);
		if (mismatch_count == 0 && bases_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("FAIL");
		$finish;
	end
endmodule
